// ===== sv/citbm_pkg.sv =====
// ----------------------------------------------------------------------------
// citbm_pkg
// Shared types, codes and helpers for the cartridge IRQ timer / bank mapper.
// ----------------------------------------------------------------------------
package citbm_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_CHR_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_EN   = 2'd2;

  // Register pages decoded from address bits 15:12
  localparam logic [3:0] PAGE_RELOAD_N0 = 4'h8;
  localparam logic [3:0] PAGE_RELOAD_N1 = 4'h9;
  localparam logic [3:0] PAGE_RELOAD_N2 = 4'hA;
  localparam logic [3:0] PAGE_RELOAD_N3 = 4'hB;
  localparam logic [3:0] PAGE_TIMER_EN  = 4'hC;
  localparam logic [3:0] PAGE_IRQ_ACK   = 4'hD;
  localparam logic [3:0] PAGE_SLOT_SEL  = 4'hE;
  localparam logic [3:0] PAGE_SLOT_DATA = 4'hF;

  // Sub-decode of slot data writes, address bits 11:10
  localparam logic [1:0] SUB_PRG_HIGH = 2'd0;
  localparam logic [1:0] SUB_NONE     = 2'd1;
  localparam logic [1:0] SUB_MIRROR   = 2'd2;
  localparam logic [1:0] SUB_CHR      = 2'd3;

  // Slot select code for the PRG window bank
  localparam logic [3:0] SLOT_WINDOW = 4'd4;

  // Window at 0x6000-0x7FFF: address bits 15:13
  localparam logic [2:0] WINDOW_PAGE = 3'b011;

  localparam logic [15:0] TIMER_WRAP = 16'hFFFF;

  localparam int NUM_PRG = 3;

  typedef struct packed {
    logic       tick;        // count one CPU cycle
    logic       reload_we;   // load one nibble of the reload value
    logic [1:0] reload_nib;
    logic       enable_we;   // enable/disable write, loads count when enabling
    logic       irq_clear;
    logic [3:0] data_nib;
  } timer_cmd_t;

  function automatic logic [7:0] clamp_bank(input logic [7:0] v, input logic [7:0] limit);
    return (v > limit) ? (v & limit) : v;
  endfunction

endpackage

// ===== sv/citbm_timer.sv =====
// ----------------------------------------------------------------------------
// citbm_timer
// 16-bit up-counting IRQ timer with nibble-loaded reload and delayed IRQ.
// ----------------------------------------------------------------------------
module citbm_timer import citbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  timer_cmd_t cmd,
  output logic       irq_line
);

  logic [15:0] reload_value, reload_value_next;
  logic [15:0] timer_count, timer_count_next;
  logic        timer_enabled, timer_enabled_next;
  logic        irq_delay, irq_delay_next;
  logic        irq_line_next;
  logic [15:0] count_inc;

  assign count_inc = timer_count + 16'd1;

  always_comb begin
    reload_value_next  = reload_value;
    timer_count_next   = timer_count;
    timer_enabled_next = timer_enabled;
    irq_delay_next     = irq_delay;
    irq_line_next      = irq_line;

    if (cmd.tick) begin
      // raise the IRQ one tick after the wrap
      if (irq_delay) begin
        irq_delay_next = 1'b0;
        irq_line_next  = 1'b1;
      end
      if (timer_enabled) begin
        if (count_inc == TIMER_WRAP) begin
          timer_count_next = reload_value;
          irq_delay_next   = 1'b1;
        end else begin
          timer_count_next = count_inc;
        end
      end
    end

    if (cmd.reload_we) begin
      reload_value_next[{cmd.reload_nib, 2'b00} +: 4] = cmd.data_nib;
    end

    if (cmd.enable_we) begin
      timer_enabled_next = |cmd.data_nib;
      if (|cmd.data_nib) begin
        timer_count_next = reload_value;
      end
    end

    // a pending delayed IRQ survives the clear
    if (cmd.irq_clear) begin
      irq_line_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value  <= '0;
      timer_count   <= '0;
      timer_enabled <= 1'b0;
      irq_delay     <= 1'b0;
      irq_line      <= 1'b0;
    end else begin
      reload_value  <= reload_value_next;
      timer_count   <= timer_count_next;
      timer_enabled <= timer_enabled_next;
      irq_delay     <= irq_delay_next;
      irq_line      <= irq_line_next;
    end
  end

endmodule

// ===== sv/cartridge_irq_timer_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_irq_timer_bank_mapper
// Cartridge bank mapper with a 16-bit up-counting IRQ timer.
// ----------------------------------------------------------------------------
// An accepted item's result beat is registered and is valid in the next cycle.
// Throughput: one item per clock; the result register is refilled in the
// cycle it drains, so input stalls only while a result beat is held.
// Reset (rst, synchronous): all mapper and timer state clears, limits go
// to 255, window reads are enabled, no result is pending.
module cartridge_irq_timer_bank_mapper import citbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        irq_out,
  output logic        mirror_vertical,
  output logic [4:0]  prg_bank_a,
  output logic [4:0]  prg_bank_b,
  output logic [4:0]  prg_bank_c,
  output logic        window_hit,
  output logic [20:0] window_rom_address,
  output logic        chr_write_valid,
  output logic [2:0]  chr_slot,
  output logic [7:0]  chr_bank_value,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       accept;
  logic       is_write;
  logic       is_slot_data;
  timer_cmd_t timer_cmd;

  logic [7:0] prg_bank_limit;
  logic [7:0] chr_bank_limit;
  logic       window_read_enable;

  logic [3:0] slot_select, slot_select_next;
  logic [4:0] prg_banks [NUM_PRG];
  logic [4:0] prg_mid [NUM_PRG];
  logic [4:0] prg_banks_next [NUM_PRG];
  logic [7:0] window_bank, window_bank_next;
  logic       mirror_state, mirror_state_next;

  logic       hit;
  logic       chr_we;
  logic [7:0] prg_cand;
  logic [7:0] prg_high_cand;
  logic [7:0] chr_clamped;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign is_write  = accept && (func == FUNC_WRITE);
  assign is_slot_data = is_write && (bus_address[15:12] == PAGE_SLOT_DATA);

  // ---- timer command decode
  always_comb begin
    timer_cmd            = '0;
    timer_cmd.tick       = accept && (func == FUNC_TICK);
    timer_cmd.data_nib   = write_data[3:0];
    timer_cmd.reload_nib = bus_address[13:12];
    if (is_write) begin
      unique case (bus_address[15:12])
        PAGE_RELOAD_N0, PAGE_RELOAD_N1,
        PAGE_RELOAD_N2, PAGE_RELOAD_N3: timer_cmd.reload_we = 1'b1;
        PAGE_TIMER_EN: begin
          timer_cmd.enable_we = 1'b1;
          timer_cmd.irq_clear = 1'b1;
        end
        PAGE_IRQ_ACK:  timer_cmd.irq_clear = 1'b1;
        default: ;
      endcase
    end
  end

  citbm_timer u_timer (
    .clk      (clk),
    .rst      (rst),
    .cmd      (timer_cmd),
    .irq_line (irq_out)
  );

  // ---- bank decode
  always_comb begin
    slot_select_next  = slot_select;
    window_bank_next  = window_bank;
    mirror_state_next = mirror_state;
    chr_we            = 1'b0;
    prg_cand          = '0;
    prg_high_cand     = '0;

    if (is_write && (bus_address[15:12] == PAGE_SLOT_SEL)) begin
      slot_select_next = write_data[3:0];
    end

    // slot-selected low nibble / window bank first
    for (int i = 0; i < NUM_PRG; i++) begin
      prg_mid[i] = prg_banks[i];
      if (is_slot_data && (slot_select == 4'(i + 1))) begin
        prg_cand   = clamp_bank({3'b000, prg_banks[i][4], write_data[3:0]}, prg_bank_limit);
        prg_mid[i] = prg_cand[4:0];
      end
    end
    if (is_slot_data && (slot_select == SLOT_WINDOW)) begin
      window_bank_next = clamp_bank(write_data, prg_bank_limit);
    end

    // then the address-decoded part, on top of the value above
    for (int i = 0; i < NUM_PRG; i++) begin
      prg_banks_next[i] = prg_mid[i];
    end
    if (is_slot_data) begin
      unique case (bus_address[11:10])
        SUB_PRG_HIGH: begin
          for (int i = 0; i < NUM_PRG; i++) begin
            if (bus_address[1:0] == 2'(i)) begin
              prg_high_cand = clamp_bank({3'b000, write_data[4], prg_mid[i][3:0]},
                                         prg_bank_limit);
              prg_banks_next[i] = prg_high_cand[4:0];
            end
          end
        end
        SUB_NONE:   ;
        SUB_MIRROR: mirror_state_next = write_data[0];
        SUB_CHR:    chr_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign chr_clamped = clamp_bank(write_data, chr_bank_limit);
  assign hit = accept && (func == FUNC_READ) && window_read_enable &&
               (bus_address[15:13] == WINDOW_PAGE);

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_limit     <= 8'hFF;
      chr_bank_limit     <= 8'hFF;
      window_read_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRG_LIMIT: prg_bank_limit     <= cfg_data;
        CFG_CHR_LIMIT: chr_bank_limit     <= cfg_data;
        CFG_WINDOW_EN: window_read_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- mapper state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_select  <= '0;
      window_bank  <= '0;
      mirror_state <= 1'b0;
      for (int i = 0; i < NUM_PRG; i++) begin
        prg_banks[i] <= '0;
      end
    end else begin
      slot_select  <= slot_select_next;
      window_bank  <= window_bank_next;
      mirror_state <= mirror_state_next;
      for (int i = 0; i < NUM_PRG; i++) begin
        prg_banks[i] <= prg_banks_next[i];
      end
    end
  end

  // State only moves on an accepted item, so while a beat is held the
  // state registers still match it and drive those fields directly.
  assign mirror_vertical = mirror_state;
  assign prg_bank_a      = prg_banks[0];
  assign prg_bank_b      = prg_banks[1];
  assign prg_bank_c      = prg_banks[2];

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window_hit         <= hit;
      window_rom_address <= hit ? {window_bank, bus_address[12:0]} : '0;
      chr_write_valid    <= chr_we;
      chr_slot           <= chr_we ? bus_address[2:0] : '0;
      chr_bank_value     <= chr_we ? chr_clamped : '0;
    end
  end

endmodule
